// File: rtl/epmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epmd_pkg;

  // Field widths
  localparam int unsigned POS_W    = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned ERR_W    = POS_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  // Q8.8 gains: fractional bits of the drive sum
  localparam int unsigned FRAC_W = 8;

  // Products and drive sum
  localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + 1 + POS_W;
  localparam int unsigned SUM_Q_W  = PROD_P_W + 1;
  localparam int unsigned DRIVE_W  = SUM_Q_W - FRAC_W;

  // Largest duty magnitude
  localparam int unsigned DUTY_MAX = 255;

  // Reset values of the registers
  localparam logic signed [POS_W-1:0] SET_POINT_RST  = 32'sd1000;
  localparam logic        [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
  localparam logic        [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;

  typedef enum logic [1:0] {
    MODE_EDGE_A = 2'd0,
    MODE_EDGE_B = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_POINT  = 2'd0,
    REG_PROP_GAIN  = 2'd1,
    REG_INTEG_GAIN = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [ERR_W-1:0] err_t;

endpackage

`default_nettype wire

// File: rtl/encoder_position_pi_motor_drive.sv
`timescale 1ns / 1ps
`default_nettype none

// Quadrature encoder position counter with a PI position loop driving a motor.
// The input stream carries encoder edge events (rising A, rising B) and control
// ticks. Edge events move the signed position count and give no result; each
// tick gives one result: direction, PWM duty (clamped to 255, never zero) and
// the position count used for that tick.
// Channels: s_t* takes requests, m_t* gives results, cfg_* writes set point,
// proportional gain and integral gain (index 0, 1, 2; other indexes ignored).
// Write the registers only while the block is idle.
// A tick passes the input register, the error stage (error and integral update),
// the product stage (gain products) and the output register (drive clamp).
// Throughput: one request per cycle while the pipeline advances; the count and
// integral are updated in a single stage, so events and ticks may follow each other in any order.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; when the receiver stalls, s_tready falls and all stages hold.
// Reset: count and integral clear, registers take 1000, 256 and 26, and the
// pipeline empties.
module encoder_position_pi_motor_drive (
  input  wire logic        clk,
  input  wire logic        rst,
  // Requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] level_a, [1] level_b, zero pad
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  // Results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [0] forward, [8:1] duty, [40:9] position, zero pad
  // Register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Registers
  epmd_pkg::pos_t                     set_point;
  logic [epmd_pkg::GAIN_W-1:0]        prop_gain;
  logic [epmd_pkg::GAIN_W-1:0]        integ_gain;

  // Controller state
  epmd_pkg::pos_t position_count;
  epmd_pkg::pos_t error_sum;

  // Input register
  logic            s1_valid;
  epmd_pkg::mode_t s1_mode;
  logic            s1_a;
  logic            s1_b;

  // Error stage
  logic            s2_valid;
  epmd_pkg::err_t  s2_err;
  epmd_pkg::pos_t  s2_sum;
  epmd_pkg::pos_t  s2_pos;

  // Product stage
  logic                                 s3_valid;
  logic signed [epmd_pkg::PROD_P_W-1:0] s3_prod_p;
  logic signed [epmd_pkg::PROD_I_W-1:0] s3_prod_i;
  epmd_pkg::pos_t                       s3_pos;

  // Output register
  logic                          forward;
  logic [epmd_pkg::DUTY_W-1:0]   duty;
  epmd_pkg::pos_t                position;

  logic advance;

  // Stage logic
  epmd_pkg::err_t                       err;
  logic signed [epmd_pkg::ERR_W:0]      sum_wide;
  epmd_pkg::pos_t                       sum_sat;
  logic signed [epmd_pkg::PROD_P_W-1:0] prod_p;
  logic signed [epmd_pkg::PROD_I_W-1:0] prod_i;
  logic signed [epmd_pkg::SUM_Q_W-1:0]  sum_q;
  logic signed [epmd_pkg::SUM_Q_W-1:0]  sum_q_adj;
  logic signed [epmd_pkg::DRIVE_W-1:0]  drive;
  logic                                 forward_next;
  logic [epmd_pkg::DUTY_W-1:0]          duty_next;

  localparam logic signed [epmd_pkg::SUM_Q_W-1:0] FracBias =
    epmd_pkg::SUM_Q_W'((1 << epmd_pkg::FRAC_W) - 1);
  localparam logic signed [epmd_pkg::DRIVE_W-1:0] DriveMax =
    epmd_pkg::DRIVE_W'(epmd_pkg::DUTY_MAX);
  localparam logic signed [epmd_pkg::ERR_W:0] SumMax =
    (epmd_pkg::ERR_W + 1)'((64'sd1 <<< (epmd_pkg::POS_W - 1)) - 1);
  localparam logic signed [epmd_pkg::ERR_W:0] SumMin =
    (epmd_pkg::ERR_W + 1)'(-(64'sd1 <<< (epmd_pkg::POS_W - 1)));

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, position, duty, forward};

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      set_point  <= epmd_pkg::SET_POINT_RST;
      prop_gain  <= epmd_pkg::PROP_GAIN_RST;
      integ_gain <= epmd_pkg::INTEG_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (epmd_pkg::reg_idx_t'(cfg_index))
        epmd_pkg::REG_SET_POINT:  set_point  <= cfg_data;
        epmd_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data[epmd_pkg::GAIN_W-1:0];
        epmd_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data[epmd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode <= epmd_pkg::mode_t'(s_tuser);
      s1_a    <= s_tdata[0];
      s1_b    <= s_tdata[1];
    end
  end

  // Error against the current count, and saturated integral
  always_comb begin
    err      = epmd_pkg::err_t'(set_point) - epmd_pkg::err_t'(position_count);
    sum_wide = (epmd_pkg::ERR_W + 1)'(error_sum) + (epmd_pkg::ERR_W + 1)'(err);
    if (sum_wide > SumMax) begin
      sum_sat = epmd_pkg::pos_t'(SumMax);
    end else if (sum_wide < SumMin) begin
      sum_sat = epmd_pkg::pos_t'(SumMin);
    end else begin
      sum_sat = sum_wide[epmd_pkg::POS_W-1:0];
    end
  end

  // Update count on edges, integral on ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      error_sum      <= '0;
    end else if (advance && s1_valid) begin
      unique case (s1_mode)
        epmd_pkg::MODE_EDGE_A: begin
          if (s1_a && !s1_b) position_count <= position_count - 32'sd1;
        end
        epmd_pkg::MODE_EDGE_B: begin
          if (!s1_a && s1_b) position_count <= position_count + 32'sd1;
        end
        epmd_pkg::MODE_TICK: begin
          error_sum <= sum_sat;
        end
        epmd_pkg::MODE_NONE: ;
      endcase
    end
  end

  // Pass ticks on with the error and the integral before this tick
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && (s1_mode == epmd_pkg::MODE_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_err <= err;
      s2_sum <= error_sum;
      s2_pos <= position_count;
    end
  end

  // Gain products
  assign prod_p = $signed({1'b0, prop_gain}) * s2_err;
  assign prod_i = $signed({1'b0, integ_gain}) * s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_prod_p <= prod_p;
      s3_prod_i <= prod_i;
      s3_pos    <= s2_pos;
    end
  end

  // Sum, truncate toward zero, clamp the magnitude
  always_comb begin
    sum_q     = epmd_pkg::SUM_Q_W'(s3_prod_p) + epmd_pkg::SUM_Q_W'(s3_prod_i);
    sum_q_adj = sum_q[epmd_pkg::SUM_Q_W-1] ? sum_q + FracBias : sum_q;
    drive     = sum_q_adj[epmd_pkg::SUM_Q_W-1:epmd_pkg::FRAC_W];
    priority if (drive > DriveMax) begin
      forward_next = 1'b1;
      duty_next    = epmd_pkg::DUTY_W'(epmd_pkg::DUTY_MAX);
    end else if (drive > 0) begin
      forward_next = 1'b1;
      duty_next    = drive[epmd_pkg::DUTY_W-1:0];
    end else if (drive < -DriveMax) begin
      forward_next = 1'b0;
      duty_next    = epmd_pkg::DUTY_W'(epmd_pkg::DUTY_MAX);
    end else if (drive < 0) begin
      forward_next = 1'b0;
      duty_next    = epmd_pkg::DUTY_W'(-drive);
    end else begin
      // Zero drive still runs forward at the smallest duty
      forward_next = 1'b1;
      duty_next    = epmd_pkg::DUTY_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      forward  <= forward_next;
      duty     <= duty_next;
      position <= s3_pos;
    end
  end

  // A result never carries a zero duty
  a_duty_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (duty != '0))
    else $error("result with zero duty");

  // The count only moves when an edge request leaves the input register
  a_count_moves_on_edge: assert property (@(posedge clk) disable iff (rst)
    !(advance && s1_valid &&
      (s1_mode == epmd_pkg::MODE_EDGE_A || s1_mode == epmd_pkg::MODE_EDGE_B))
    |=> $stable(position_count))
    else $error("position count changed without an edge");

  // The integral only moves when a tick leaves the input register
  a_sum_moves_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(advance && s1_valid && s1_mode == epmd_pkg::MODE_TICK)
    |=> $stable(error_sum))
    else $error("integral changed without a tick");

  // A stalled pipeline keeps every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid)))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
